>>> sv/dds_pkg.sv
package dds_pkg;

  localparam int IntDigits  = 8;
  localparam int FracDigits = 4;

  localparam int RadW  = 40;
  localparam int RootW = 27;
  localparam int RemW  = 28;

  // scaled radicand holds one bit pair per root bit
  localparam int SW     = 2 * RootW;
  localparam int IterW  = $clog2(RootW);
  localparam int StepW  = RemW + 2;

  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  localparam longint unsigned RadMax = pow10(IntDigits + FracDigits) - 1;
  localparam longint unsigned Scale  = pow10(FracDigits);
  localparam int ScaleW = $clog2(Scale + 1);

  localparam logic [RadW-1:0]   RadMaxK   = RadW'(RadMax);
  localparam logic [ScaleW-1:0] ScaleK    = ScaleW'(Scale);
  localparam logic [IterW-1:0]  IterFirst = IterW'(RootW - 1);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScale = 4'b0010,
    StIter  = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  typedef struct packed {
    logic scale;
    logic iter;
    logic done;
  } ctrl_t;

endpackage

>>> sv/dds_step.sv
module dds_step (
  input  logic [dds_pkg::RemW-1:0]  rem_i,
  input  logic [1:0]                pair_i,
  input  logic [dds_pkg::RootW-1:0] root_i,
  output logic [dds_pkg::RemW-1:0]  rem_o,
  output logic [dds_pkg::RootW-1:0] root_o
);
  import dds_pkg::*;

  logic [StepW-1:0] rem_sh;
  logic [StepW-1:0] trial;
  logic [StepW-1:0] diff;
  logic             ge;

  // trial value is four times the partial root plus one
  assign rem_sh = {rem_i, pair_i};
  assign trial  = {1'b0, root_i, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  assign rem_o  = ge ? diff[RemW-1:0] : rem_sh[RemW-1:0];
  assign root_o = {root_i[RootW-2:0], ge};

endmodule

>>> sv/dds_seq.sv
module dds_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output dds_pkg::ctrl_t ctrl_o,
  output logic           busy_o
);
  import dds_pkg::*;

  state_e           state_q, state_d;
  logic [IterW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StScale;
        end
      end
      StScale: begin
        state_d = StIter;
        cnt_d   = IterFirst;
      end
      StIter: begin
        if (cnt_q == '0) begin
          state_d = StDone;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign ctrl_o.scale = state_q == StScale;
  assign ctrl_o.iter  = state_q == StIter;
  assign ctrl_o.done  = state_q == StDone;
  assign busy_o       = state_q != StIdle;

endmodule

>>> sv/decimal_digit_square_root.sv
// Square root of a fixed-point radicand with four fractional decimal digits (value
// times 10000, above 999999999999 saturated). root_o is the root times 10000
// truncated, remainder_o is radicand*10000 minus root_o squared and exact_o flags a
// zero remainder. A transfer is taken when start_i is high and busy_o is low; busy_o
// then stays high and the result is shown for one cycle with done_o, and the
// receiver cannot stall it. No new transfer is taken until the result has been shown:
// a scale state multiplies the radicand by 10000, then a single compare-subtract
// unit settles one root bit per cycle, then a done state presents the result.
module decimal_digit_square_root (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [dds_pkg::RadW-1:0]  radicand_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [dds_pkg::RootW-1:0] root_o,
  output logic                      exact_o,
  output logic [dds_pkg::RemW-1:0]  remainder_o
);
  import dds_pkg::*;

  ctrl_t            ctrl;
  logic             accept;
  logic [RadW-1:0]  rad_q;
  logic [SW-1:0]    s_q;
  logic [SW-1:0]    prod;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [RemW-1:0]  rem_next;
  logic [RootW-1:0] root_next;

  assign accept = start_i && !busy_o;
  assign prod   = SW'(rad_q) * SW'(ScaleK);

  dds_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o)
  );

  dds_step u_step (
    .rem_i  (rem_q),
    .pair_i (s_q[SW-1 -: 2]),
    .root_i (root_q),
    .rem_o  (rem_next),
    .root_o (root_next)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rad_q <= (radicand_i > RadMaxK) ? RadMaxK : radicand_i;
    end
    if (ctrl.scale) begin
      s_q    <= prod;
      rem_q  <= '0;
      root_q <= '0;
    end else if (ctrl.iter) begin
      s_q    <= {s_q[SW-3:0], 2'b00};
      rem_q  <= rem_next;
      root_q <= root_next;
    end
  end

  assign done_o      = ctrl.done;
  assign root_o      = root_q;
  assign remainder_o = rem_q;
  assign exact_o     = rem_q == '0;

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe outside a busy period");

  a_accept_no_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("result strobe right after a transfer was taken");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy_o && !done_o))
    else $error("block not idle after the result");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ({1'b0, remainder_o} <= {1'b0, root_o, 1'b0}))
    else $error("remainder above twice the root");

endmodule
